// ===== design/ttm_pkg.sv =====
`default_nettype none
package ttm_pkg;

  localparam int MAX_PULSES = 8;
  localparam int FRAC_BITS = 16;
  localparam int PULSE_IW = $clog2(MAX_PULSES);
  localparam int PULSE_CW = $clog2(MAX_PULSES + 1);

  localparam logic [63:0] MAG_CAP = 64'h2000_0000_0000_0000;
  localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] TEMP_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  localparam logic [2:0] REG_PULSE_COUNT = 3'd0;
  localparam logic [2:0] REG_PUMP_POWER = 3'd1;
  localparam logic [2:0] REG_INV_WIDTH = 3'd2;
  localparam logic [2:0] REG_COUPLING = 3'd3;
  localparam logic [2:0] REG_INV_LATTICE = 3'd4;
  localparam logic [2:0] REG_GAMMA = 3'd5;
  localparam logic [2:0] REG_TIME_STEP = 3'd6;
  localparam logic [2:0] REG_INV_COOL = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DEN, S_PLS, S_X, S_Y, S_Z, S_R, S_RM, S_AE, S_ACC,
    S_NUM, S_DIV0, S_DIV, S_TE, S_H, S_H1, S_H2, S_H3, S_K1, S_K2, S_RESP
  } state_t;

  function automatic logic [30:0] root_factor(input logic [2:0] j);
    logic [30:0] v;
    unique case (j)
      3'd0: v = 31'd759250125;
      3'd1: v = 31'd902905651;
      3'd2: v = 31'd984625594;
      3'd3: v = 31'd1028218693;
      3'd4: v = 31'd1050733751;
      3'd5: v = 31'd1062175491;
      3'd6: v = 31'd1067942999;
      default: v = 31'd1070838486;
    endcase
    return v;
  endfunction

  // Truncating shift of a full product, clamped to the magnitude cap.
  function automatic logic [63:0] mul_fix(input logic [127:0] p, input logic sel30);
    logic [127:0] s;
    logic [63:0] r;
    s = sel30 ? (p >> 30) : (p >> FRAC_BITS);
    r = s[63:0];
    if (s[127:64] != 64'd0) begin
      r = MAG_CAP;
    end else if (r > MAG_CAP) begin
      r = MAG_CAP;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_temp(input logic signed [63:0] v);
    logic [31:0] r;
    if (v < 0) begin
      r = 32'd0;
    end else if (v > $signed({32'd0, TEMP_MAX})) begin
      r = TEMP_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic temp_out_of_range(input logic signed [63:0] v);
    return (v < 0) || (v > $signed({32'd0, TEMP_MAX}));
  endfunction

endpackage
`default_nettype wire

// ===== design/two_temperature_model_step_unit.sv =====
`default_nettype none
// Forward-Euler step of the two-temperature laser heating model in Q16.16 fixed
// point. A start item sets the electron, lattice and ambient temperatures, a load
// item writes one pulse table entry, and a step item sums the Gaussian pulse powers
// at its time and advances both temperatures; every item returns one result with
// the current temperatures and the fault and saturation flags. All products go
// through one shared 32x32 multiplier that takes four passes per product, and the
// electron update uses a divider that retires one quotient bit per cycle. Start and
// load items go straight from idle to the result state. A step runs longer for each
// summed pulse and for every set bit of the exp table index; a zero divisor ends a
// step early with the fault flag set and both temperatures unchanged. The block
// takes no new item until the result is taken.
module two_temperature_model_step_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  pulse_index,
  input  wire logic [31:0] pulse_delay,
  input  wire logic [31:0] pulse_amp,
  input  wire logic [31:0] step_time,
  input  wire logic [31:0] start_temp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] electron_temp,
  output logic      [31:0] lattice_temp,
  output logic             div_fault,
  output logic             saturated
);

  logic [3:0]  pulse_count;
  logic [31:0] pump_power, inv_pulse_width, coupling, inv_lattice_heat;
  logic [31:0] electron_heat_coeff, time_step, inv_cooling_time;

  logic [31:0] te, tl, amb, now;
  logic [31:0] delay_mem [ttm_pkg::MAX_PULSES];
  logic [31:0] scale_mem [ttm_pkg::MAX_PULSES];

  ttm_pkg::state_t state, state_next, ret;

  logic [63:0]  ma, mb;
  logic [127:0] acc;
  logic [1:0]   mcnt;
  logic [63:0]  pp;
  logic [1:0]   pp_shift;
  logic [63:0]  res16, res30;

  logic [ttm_pkg::PULSE_CW-1:0] pidx, nlim;
  logic [5:0]  kexp;
  logic [7:0]  fb;
  logic [3:0]  rj;
  logic [30:0] r, e;
  logic [63:0] ptot, den, q, rem, dlo;
  logic [5:0]  dcnt;
  logic        dneg, numneg, d2neg, daneg;
  logic [63:0] heat;
  logic        fault, sat;

  logic        cfg_wr, in_acc;
  logic [31:0] off;
  logic [63:0] cap_q;
  logic signed [63:0] te_new;
  logic [32:0] d2, da, dd;
  logic [63:0] div_rs;
  logic        div_take;
  logic signed [63:0] num, delta, tl_new;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    unique case (paddr[4:2])
      ttm_pkg::REG_PULSE_COUNT: prdata = {28'd0, pulse_count};
      ttm_pkg::REG_PUMP_POWER:  prdata = pump_power;
      ttm_pkg::REG_INV_WIDTH:   prdata = inv_pulse_width;
      ttm_pkg::REG_COUPLING:    prdata = coupling;
      ttm_pkg::REG_INV_LATTICE: prdata = inv_lattice_heat;
      ttm_pkg::REG_GAMMA:       prdata = electron_heat_coeff;
      ttm_pkg::REG_TIME_STEP:   prdata = time_step;
      default:                  prdata = inv_cooling_time;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= 4'd1;
      pump_power <= 32'd0;
      inv_pulse_width <= ttm_pkg::ONE_Q[31:0];
      coupling <= 32'd0;
      inv_lattice_heat <= ttm_pkg::ONE_Q[31:0];
      electron_heat_coeff <= ttm_pkg::ONE_Q[31:0];
      time_step <= ttm_pkg::ONE_Q[31:0];
      inv_cooling_time <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        ttm_pkg::REG_PULSE_COUNT: pulse_count <= pwdata[3:0];
        ttm_pkg::REG_PUMP_POWER:  pump_power <= pwdata;
        ttm_pkg::REG_INV_WIDTH:   inv_pulse_width <= pwdata;
        ttm_pkg::REG_COUPLING:    coupling <= pwdata;
        ttm_pkg::REG_INV_LATTICE: inv_lattice_heat <= pwdata;
        ttm_pkg::REG_GAMMA:       electron_heat_coeff <= pwdata;
        ttm_pkg::REG_TIME_STEP:   time_step <= pwdata;
        default:                  inv_cooling_time <= pwdata;
      endcase
    end
  end

  assign pp = ma[mcnt[1]*32 +: 32] * mb[mcnt[0]*32 +: 32];
  assign pp_shift = {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
  assign res16 = ttm_pkg::mul_fix(acc, 1'b0);
  assign res30 = ttm_pkg::mul_fix(acc, 1'b1);

  assign off = (now >= delay_mem[pidx[ttm_pkg::PULSE_IW-1:0]])
             ? now - delay_mem[pidx[ttm_pkg::PULSE_IW-1:0]]
             : delay_mem[pidx[ttm_pkg::PULSE_IW-1:0]] - now;
  assign dd = {1'b0, te} - {1'b0, tl};
  assign d2 = {1'b0, te} - {1'b0, tl};
  assign da = {1'b0, tl} - {1'b0, amb};
  assign num = $signed(ptot) - (dneg ? -$signed(res16) : $signed(res16));
  assign cap_q = (q > ttm_pkg::MAG_CAP) ? ttm_pkg::MAG_CAP : q;
  assign te_new = $signed({32'd0, te}) + (numneg ? -$signed(cap_q) : $signed(cap_q));
  assign div_rs = {rem[62:0], dlo[63]};
  assign div_take = rem[63] || (div_rs >= den);
  assign delta = (d2neg ? -$signed(heat) : $signed(heat))
               - (daneg ? -$signed(res16) : $signed(res16));
  assign tl_new = $signed({32'd0, tl}) + delta;

  always_comb begin
    state_next = state;
    unique case (state)
      ttm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == ttm_pkg::OP_STEP) ? ttm_pkg::S_MUL : ttm_pkg::S_RESP;
        end
      end
      ttm_pkg::S_MUL: if (mcnt == 2'd3) state_next = ret;
      ttm_pkg::S_DEN: begin
        state_next = (acc[63:0] == 64'd0) ? ttm_pkg::S_RESP : ttm_pkg::S_PLS;
      end
      ttm_pkg::S_Z: state_next = ttm_pkg::S_R;
      ttm_pkg::S_R: begin
        if (rj == 4'd8 || fb[7]) state_next = ttm_pkg::S_MUL;
      end
      ttm_pkg::S_RM: state_next = ttm_pkg::S_R;
      ttm_pkg::S_ACC: state_next = ttm_pkg::S_PLS;
      ttm_pkg::S_DIV0: begin
        state_next = (acc[127:64] >= den) ? ttm_pkg::S_TE : ttm_pkg::S_DIV;
      end
      ttm_pkg::S_DIV: if (dcnt == 6'd0) state_next = ttm_pkg::S_TE;
      ttm_pkg::S_TE: state_next = ttm_pkg::S_H;
      ttm_pkg::S_K2: state_next = ttm_pkg::S_RESP;
      ttm_pkg::S_RESP: if (out_ready) state_next = ttm_pkg::S_IDLE;
      default: state_next = ttm_pkg::S_MUL;
    endcase
  end

  always_comb begin
    in_ready = (state == ttm_pkg::S_IDLE);
    out_valid = (state == ttm_pkg::S_RESP);
    electron_temp = te;
    lattice_temp = tl;
    div_fault = fault;
    saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      te <= 32'd0;
      tl <= 32'd0;
      amb <= 32'd0;
      fault <= 1'b0;
      sat <= 1'b0;
      mcnt <= 2'd0;
      ret <= ttm_pkg::S_IDLE;
    end else begin
      unique case (state)
        ttm_pkg::S_IDLE: begin
          if (in_acc) begin
            fault <= 1'b0;
            sat <= 1'b0;
            if (opcode == ttm_pkg::OP_START) begin
              te <= start_temp;
              tl <= start_temp;
              amb <= start_temp;
            end else if (opcode == ttm_pkg::OP_LOAD) begin
              if ({1'b0, pulse_index} < 4'(ttm_pkg::MAX_PULSES)) begin
                delay_mem[pulse_index[ttm_pkg::PULSE_IW-1:0]] <= pulse_delay;
                scale_mem[pulse_index[ttm_pkg::PULSE_IW-1:0]] <= pulse_amp;
              end
            end else if (opcode == ttm_pkg::OP_STEP) begin
              now <= step_time;
              ma <= {32'd0, electron_heat_coeff};
              mb <= {32'd0, te};
              acc <= 128'd0;
              mcnt <= 2'd0;
              ret <= ttm_pkg::S_DEN;
            end
          end
        end
        ttm_pkg::S_MUL: begin
          unique case (pp_shift)
            2'd0: acc <= acc + {64'd0, pp};
            2'd1: acc <= acc + {32'd0, pp, 32'd0};
            default: acc <= acc + {pp, 64'd0};
          endcase
          mcnt <= mcnt + 2'd1;
        end
        ttm_pkg::S_DEN: begin
          den <= acc[63:0];
          if (acc[63:0] == 64'd0) begin
            fault <= 1'b1;
          end
          ptot <= 64'd0;
          pidx <= '0;
          nlim <= (pulse_count > 4'(ttm_pkg::MAX_PULSES))
                ? ttm_pkg::PULSE_CW'(ttm_pkg::MAX_PULSES)
                : ttm_pkg::PULSE_CW'(pulse_count);
        end
        ttm_pkg::S_PLS: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          if (pidx == nlim) begin
            dneg <= dd[32];
            ma <= {32'd0, coupling};
            mb <= {32'd0, dd[32] ? -dd[31:0] : dd[31:0]};
            ret <= ttm_pkg::S_NUM;
          end else begin
            ma <= {32'd0, off};
            mb <= {32'd0, inv_pulse_width};
            ret <= ttm_pkg::S_X;
          end
        end
        ttm_pkg::S_X: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          if (res16 >= (ttm_pkg::ONE_Q << 2)) begin
            e <= 31'd0;
            ma <= {32'd0, pump_power};
            mb <= {32'd0, scale_mem[pidx[ttm_pkg::PULSE_IW-1:0]]};
            ret <= ttm_pkg::S_AE;
          end else begin
            ma <= res16;
            mb <= res16;
            ret <= ttm_pkg::S_Y;
          end
        end
        ttm_pkg::S_Y: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= res16;
          mb <= {32'd0, ttm_pkg::LOG2E_Q30};
          ret <= ttm_pkg::S_Z;
        end
        ttm_pkg::S_Z: begin
          kexp <= res30[ttm_pkg::FRAC_BITS +: 6];
          fb <= res30[ttm_pkg::FRAC_BITS-1 -: 8];
          r <= ttm_pkg::Q30_ONE;
          rj <= 4'd0;
        end
        ttm_pkg::S_R: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          if (rj == 4'd8) begin
            e <= (kexp >= 6'd31) ? 31'd0 : (r >> kexp);
            ma <= {32'd0, pump_power};
            mb <= {32'd0, scale_mem[pidx[ttm_pkg::PULSE_IW-1:0]]};
            ret <= ttm_pkg::S_AE;
          end else if (fb[7]) begin
            ma <= {33'd0, r};
            mb <= {33'd0, ttm_pkg::root_factor(rj[2:0])};
            ret <= ttm_pkg::S_RM;
          end else begin
            fb <= {fb[6:0], 1'b0};
            rj <= rj + 4'd1;
          end
        end
        ttm_pkg::S_RM: begin
          r <= res30[30:0];
          fb <= {fb[6:0], 1'b0};
          rj <= rj + 4'd1;
        end
        ttm_pkg::S_AE: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= res16;
          mb <= {33'd0, e};
          ret <= ttm_pkg::S_ACC;
        end
        ttm_pkg::S_ACC: begin
          ptot <= (ptot + res30 > ttm_pkg::MAG_CAP) ? ttm_pkg::MAG_CAP : ptot + res30;
          pidx <= pidx + 1'b1;
        end
        ttm_pkg::S_NUM: begin
          numneg <= num[63];
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= num[63] ? 64'(-num) : 64'(num);
          mb <= {time_step, 32'd0} >> (32 - ttm_pkg::FRAC_BITS);
          ret <= ttm_pkg::S_DIV0;
        end
        ttm_pkg::S_DIV0: begin
          if (acc[127:64] >= den) begin
            q <= ttm_pkg::MAG_CAP;
          end else begin
            q <= 64'd0;
          end
          rem <= acc[127:64];
          dlo <= acc[63:0];
          dcnt <= 6'd63;
        end
        ttm_pkg::S_DIV: begin
          rem <= div_take ? div_rs - den : div_rs;
          q <= {q[62:0], div_take};
          dlo <= {dlo[62:0], 1'b0};
          dcnt <= dcnt - 6'd1;
        end
        ttm_pkg::S_TE: begin
          te <= ttm_pkg::clamp_temp(te_new);
          if (ttm_pkg::temp_out_of_range(te_new)) sat <= 1'b1;
        end
        ttm_pkg::S_H: begin
          d2neg <= d2[32];
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= {32'd0, coupling};
          mb <= {32'd0, d2[32] ? -d2[31:0] : d2[31:0]};
          ret <= ttm_pkg::S_H1;
        end
        ttm_pkg::S_H1: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= res16;
          mb <= {32'd0, time_step};
          ret <= ttm_pkg::S_H2;
        end
        ttm_pkg::S_H2: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= res16;
          mb <= {32'd0, inv_lattice_heat};
          ret <= ttm_pkg::S_H3;
        end
        ttm_pkg::S_H3: begin
          heat <= res16;
          daneg <= da[32];
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= {32'd0, da[32] ? -da[31:0] : da[31:0]};
          mb <= {32'd0, time_step};
          ret <= ttm_pkg::S_K1;
        end
        ttm_pkg::S_K1: begin
          acc <= 128'd0;
          mcnt <= 2'd0;
          ma <= res16;
          mb <= {32'd0, inv_cooling_time};
          ret <= ttm_pkg::S_K2;
        end
        ttm_pkg::S_K2: begin
          tl <= ttm_pkg::clamp_temp(tl_new);
          if (ttm_pkg::temp_out_of_range(tl_new)) sat <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and result handshakes open together");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("new item taken before the result was shown");

  a_fault_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_fault) |-> !saturated)
    else $error("fault result also flagged as saturated");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(electron_temp)
                                   && $stable(lattice_temp)))
    else $error("pending result changed");

endmodule
`default_nettype wire
